// ----- src/bsst_pkg.sv -----
// shared types and constants of the bounded set span tracker
package bsst_pkg;

    localparam int COUNT_W = 11;
    localparam int VALUE_W = 32;
    localparam int SPAN_W  = 32;

    // capacity after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

    // result status codes
    localparam logic [1:0] ST_SPANS = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FEW   = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    // input mode codes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [COUNT_W-1:0] count;
        logic [SPAN_W-1:0]  shortest_span;
        logic [SPAN_W-1:0]  longest_span;
    } t_out_item;

    // what the finishing step does to the set
    typedef enum logic [1:0] {
        K_ADD,
        K_FULL,
        K_CLR
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic  take;
        logic  rd;
        logic  fin;
        t_kind kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mode_clr;
        logic full;
        logic cnt_zero;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// ----- src/bounded_set_span_tracker.sv -----
// top level of the bounded set span tracker
//
//  channel   direction  handshake        payload
//  in        input      valid / stall    t_in_item  (mode, value)
//  out       output     valid / stall    t_out_item (status, count, spans)
//  cfg       input      valid / ready    capacity, 11 bits
//
// clear, rejected add and add to an empty set: decide, then finish, with no store read
// add to a set of n values: decide, scan, wait, finish, one store read per held value
// the scan over the value store is longest with
// SET_DEPTH - 1 values held
// reset is synchronous and active low; no clearing pass, the store is read
// only below the fill count
// a new beat is taken while the last result waits; a stalled result holds
// the finishing step until the result register is free
module bounded_set_span_tracker #(
    parameter int SET_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bsst_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bsst_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bsst_pkg::COUNT_W-1:0] i_cfg_data
);
    import bsst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // configuration is to be written only while idle; the block does not enforce it
    assign o_cfg_ready = 1'b1;

    // sequencing
    bsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // store and arithmetic
    bsst_dp #(
        .SET_DEPTH (SET_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    // an accepted beat keeps the input stalled until its result is built
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a beat was taken");

    // a cleared result carries nothing
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_CLEAR)) |->
        ((o_out_data.count == '0) && (o_out_data.shortest_span == '0) &&
         (o_out_data.longest_span == '0)))
        else $error("clear result not empty");

    // valid spans need two values
    a_spans_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_SPANS)) |->
        (o_out_data.count >= COUNT_W'(2)))
        else $error("spans reported with fewer than two values");

    // the scan and the result register are never both finishing a beat
    a_no_read_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.rd && w_cmd.fin))
        else $error("store read while finishing");

endmodule

// ----- src/bsst_ctrl.sv -----
// sequencing state machine of the bounded set span tracker
module bsst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bsst_pkg::t_sts i_sts,
    output bsst_pkg::t_cmd o_cmd
);
    import bsst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_WAIT,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    // next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.mode_clr) begin
                    n_kind  = K_CLR;
                    n_state = S_FIN;
                end else if (i_sts.full) begin
                    n_kind  = K_FULL;
                    n_state = S_FIN;
                end else if (i_sts.cnt_zero) begin
                    n_kind  = K_ADD;
                    n_state = S_FIN;
                end else begin
                    n_kind  = K_ADD;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and kind registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_ADD;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // commands
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.take = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd   = (r_state == S_SCAN);
    assign o_cmd.fin  = (r_state == S_FIN) && i_sts.out_free;
    assign o_cmd.kind = r_kind;

endmodule

// ----- src/bsst_dp.sv -----
// value store, span registers and result register of the tracker
module bsst_dp #(
    parameter int SET_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bsst_pkg::t_in_item              i_in_data,
    input  logic                            i_cfg_valid,
    input  logic [bsst_pkg::COUNT_W-1:0]    i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output bsst_pkg::t_out_item             o_out_data,
    input  bsst_pkg::t_cmd                  i_cmd,
    output bsst_pkg::t_sts                  o_sts
);
    import bsst_pkg::*;

    localparam int AW      = $clog2(SET_DEPTH);
    localparam int CNT_MAX = (1 << COUNT_W) - 1;
    localparam int LIM_MAX = (SET_DEPTH < CNT_MAX) ? SET_DEPTH : CNT_MAX;

    logic [VALUE_W-1:0] r_mem [SET_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_rd_vld;

    logic [COUNT_W-1:0] r_cap;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_idx;
    logic               r_mode;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_min, n_min;
    logic [VALUE_W-1:0] r_max, n_max;
    logic [SPAN_W-1:0]  r_gap, n_gap;
    logic [SPAN_W-1:0]  w_dist;
    logic [COUNT_W-1:0] w_limit;
    logic               r_out_vld;
    t_out_item          r_out, n_out;

    // effective limit is the smaller of capacity and depth
    assign w_limit = (r_cap < COUNT_W'(LIM_MAX)) ? r_cap : COUNT_W'(LIM_MAX);

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // latch the incoming beat and step the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode  <= i_in_data.mode;
            r_value <= i_in_data.value;
            r_idx   <= '0;
        end else if (i_cmd.rd) begin
            r_idx <= r_idx + COUNT_W'(1);
        end
    end

    // value store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && (i_cmd.kind == K_ADD)) begin
            r_mem[AW'(r_count)] <= r_value;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
        end
    end

    // distance between a held value and the new one
    always_comb begin
        if ($signed(r_rd_data) < $signed(r_value)) begin
            w_dist = r_value - r_rd_data;
        end else begin
            w_dist = r_rd_data - r_value;
        end
    end

    // shortest gap from the scan reads, set update and result at the finishing step
    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        n_max   = r_max;
        n_gap   = r_gap;
        if (r_rd_vld && (w_dist < r_gap)) begin
            n_gap = w_dist;
        end
        n_out.status        = ST_FULL;
        n_out.count         = r_count;
        n_out.shortest_span = '0;
        n_out.longest_span  = '0;
        if (i_cmd.fin) begin
            case (i_cmd.kind)
                K_CLR: begin
                    n_count = '0;
                    n_min   = '0;
                    n_max   = '0;
                    n_gap   = '1;
                end
                K_ADD: begin
                    n_count = r_count + COUNT_W'(1);
                    if (r_count == '0) begin
                        n_min = r_value;
                        n_max = r_value;
                    end else begin
                        if ($signed(r_value) < $signed(r_min)) begin
                            n_min = r_value;
                        end
                        if ($signed(r_max) < $signed(r_value)) begin
                            n_max = r_value;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // result fields from the updated set
        case (i_cmd.kind)
            K_CLR:   n_out.status = ST_CLEAR;
            K_ADD:   n_out.status = (n_count >= COUNT_W'(2)) ? ST_SPANS : ST_FEW;
            default: n_out.status = ST_FULL;
        endcase
        n_out.count = n_count;
        if (n_count >= COUNT_W'(2)) begin
            n_out.shortest_span = n_gap;
            n_out.longest_span  = n_max - n_min;
        end
    end

    // set state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_gap   <= '1;
        end else begin
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_gap   <= n_gap;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // status to the controller
    assign o_sts.mode_clr  = (r_mode == MODE_CLEAR);
    assign o_sts.full      = (r_count >= w_limit);
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.scan_last = ((r_idx + COUNT_W'(1)) == r_count);
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the bounded set span tracker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsst_pkg::*;

    localparam int SET_DEPTH = 1024;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_ITEMS = 420;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    // own copy of the set and its running spans
    logic [COUNT_W-1:0]        cap_reg = CAP_RESET;
    logic signed [VALUE_W-1:0] held_values[$];
    logic signed [VALUE_W-1:0] min_val = '0;
    logic signed [VALUE_W-1:0] max_val = '0;
    logic [SPAN_W-1:0]         min_gap = '1;

    t_out_item pending_results[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int n_clears = 0;
    int n_rejects = 0;
    int n_spans = 0;
    int peak_held = 0;
    int cap_writes = 0;
    int burst_left = 1;
    bit sending = 1'b0;

    bounded_set_span_tracker #(
        .SET_DEPTH(SET_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected result for one accepted beat, updating the tracked set
    function automatic t_out_item predict_spans(input t_in_item it);
        t_out_item                 res;
        int                        limit;
        logic signed [VALUE_W-1:0] v;
        logic [SPAN_W-1:0]         d;
        res = '0;
        v = it.value;
        limit = (cap_reg < SET_DEPTH) ? int'(cap_reg) : SET_DEPTH;
        if (it.mode == MODE_CLEAR) begin
            held_values.delete();
            min_val = '0;
            max_val = '0;
            min_gap = '1;
            res.status = ST_CLEAR;
            return res;
        end
        if (held_values.size() >= limit) begin
            res.status = ST_FULL;
        end else begin
            // distance to every held value, unsigned so it never overflows
            foreach (held_values[k]) begin
                d = (held_values[k] < v) ? SPAN_W'(v - held_values[k])
                                         : SPAN_W'(held_values[k] - v);
                if (d < min_gap) min_gap = d;
            end
            if (held_values.size() == 0) begin
                min_val = v;
                max_val = v;
            end else begin
                if (v < min_val) min_val = v;
                if (v > max_val) max_val = v;
            end
            held_values = {held_values, v};
            if (held_values.size() > peak_held) peak_held = held_values.size();
            res.status = (held_values.size() >= 2) ? ST_SPANS : ST_FEW;
        end
        res.count = COUNT_W'(held_values.size());
        if (held_values.size() >= 2) begin
            res.shortest_span = min_gap;
            res.longest_span  = SPAN_W'(max_val - min_val);
        end
        return res;
    endfunction

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: compare every accepted beat with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with none expected, actual %p", $time, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", 32'(want.status), 32'(o_out_data.status));
                report_field("count", 32'(want.count), 32'(o_out_data.count));
                report_field("shortest_span", want.shortest_span, o_out_data.shortest_span);
                report_field("longest_span", want.longest_span, o_out_data.longest_span);
                case (want.status)
                    ST_CLEAR: n_clears++;
                    ST_FULL:  n_rejects++;
                    ST_SPANS: n_spans++;
                    default:  ;
                endcase
            end
        end
    end

    // receiver stall pattern: stretches of differing stall density, some with none
    int stall_pct = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                2:       stall_pct = 40;
                default: stall_pct = 75;
            endcase
            stall_left = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // one input beat; valid stays high into the next beat unless a gap is due
    task automatic send_item(input t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        sending = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results = {pending_results, predict_spans(it)};
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                sending = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic stop_sending();
        if (sending) begin
            i_in_valid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    task automatic add_value(input logic signed [VALUE_W-1:0] v);
        t_in_item it;
        it.mode  = MODE_ADD;
        it.value = v;
        send_item(it);
    endtask

    // clear beat; the value field carries noise
    task automatic clear_set();
        t_in_item it;
        it.mode  = MODE_CLEAR;
        it.value = $urandom;
        send_item(it);
    endtask

    // capacity is only changed with the block drained
    task automatic write_capacity(input logic [COUNT_W-1:0] cap);
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = cap;
        cap_writes++;
    endtask

    // value mix: full range, near zero, near the extremes, next to held values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int off;
        case ($urandom_range(0, 5))
            0: begin
                off = $urandom_range(0, 12);
                return off - 6;
            end
            1: return V_MIN + int'($urandom_range(0, 3));
            2: return V_MAX - int'($urandom_range(0, 3));
            3: begin
                if (held_values.size() == 0) return $urandom;
                off = $urandom_range(0, 2);
                return held_values[$urandom_range(0, held_values.size() - 1)] + off - 1;
            end
            default: return $urandom;
        endcase
    endfunction

    // spans at reset capacity: empty clear, duplicates, gaps around zero, extremes
    task automatic test_basic_spans();
        clear_set();
        add_value(0);
        add_value(0);
        clear_set();
        add_value(-1);
        add_value(1);
        add_value(0);
        clear_set();
        add_value(V_MIN);
        add_value(V_MAX);
        add_value(0);
        clear_set();
    endtask

    // capacity zero, one and two, rejections with and without spans
    task automatic test_capacity_limits();
        write_capacity(11'd0);
        add_value(5);
        clear_set();
        write_capacity(11'd1);
        add_value(7);
        add_value(8);
        clear_set();
        write_capacity(11'd2);
        add_value(10);
        add_value(-10);
        add_value(3);
        clear_set();
    endtask

    // capacity above depth and at depth, then lowered below the held count
    task automatic test_wide_capacity();
        write_capacity('1);
        add_value(V_MIN);
        add_value(V_MAX);
        repeat (100) add_value($urandom);
        add_value(0);
        write_capacity(11'd1024);
        add_value(-3);
        write_capacity(11'd50);
        add_value(3);
        clear_set();
    endtask

    // random phases, each under its own capacity
    task automatic test_random_mix();
        int done;
        int phase_len;
        logic [COUNT_W-1:0] cap;
        t_in_item it;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cap = 11'd0;
                1:       cap = 11'd1;
                2:       cap = 11'd2;
                3:       cap = 11'd1024;
                4:       cap = '1;
                5:       cap = COUNT_W'($urandom_range(3, 2047));
                default: cap = COUNT_W'($urandom_range(2, 24));
            endcase
            write_capacity(cap);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                if ($urandom_range(0, 11) == 0) begin
                    clear_set();
                end else begin
                    it.mode  = MODE_ADD;
                    it.value = pick_value();
                    send_item(it);
                end
            end
            done += phase_len;
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_spans();
        test_capacity_limits();
        test_wide_capacity();
        test_random_mix();
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d beats: %0d clears, %0d rejected adds, %0d span results",
                 items_sent, n_clears, n_rejects, n_spans);
        $display("largest set held %0d values over %0d capacity settings",
                 peak_held, cap_writes);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #60_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
